### design/p2g_pkg.sv
// Shared types, constants and helpers for the pixel-to-ground lookup block.
// Used by p2g_cell, p2g_div, p2g_calc and pixel_to_ground_lut_interp_top.
package p2g_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = 5;
	localparam int CMP_W       = (IDX_W >= CNT_W) ? IDX_W + 1 : CNT_W;

	// Field widths
	localparam int PIX_W = 12;
	localparam int M_W   = 32;
	localparam int R_W   = 14;   // signed query row, bottom origin
	localparam int DX_W  = 13;   // signed column offset from center

	// Arithmetic widths
	localparam int MUL_A_W = 46;
	localparam int MUL_B_W = 14;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int TERM_W  = 45;
	localparam int DIV_W   = 58;
	localparam int DVS_W   = 13;
	localparam int DCNT_W  = $clog2(DIV_W + 1);

	// Opcodes
	localparam logic [1:0] OP_WR_VERT = 2'd0;
	localparam logic [1:0] OP_WR_HORZ = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd0;
	localparam logic [1:0] CFG_SENSOR_WIDTH = 2'd1;
	localparam logic [1:0] CFG_VERT_COUNT   = 2'd2;
	localparam logic [1:0] CFG_HORZ_COUNT   = 2'd3;

	localparam logic [PIX_W-1:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [PIX_W-1:0] SENSOR_WIDTH_RST = 12'd640;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_VERT  = 2'd1,
		ST_NO_HORZ  = 2'd2,
		ST_ZERO_GAP = 2'd3
	} status_t;

	// Table write transaction broadcast to every cell
	typedef struct packed {
		logic              vert_we;
		logic              horz_we;
		logic [3:0]        index;
		logic [PIX_W-1:0]  row;
		logic [PIX_W-1:0]  span;
		logic [M_W-1:0]    meters;
	} tbl_wr_t;

	// Search packet moving down the cell chain
	typedef struct packed {
		logic                  vld;
		logic signed [R_W-1:0] r;
		logic                  v_found;
		logic                  v_first;
		logic [PIX_W-1:0]      v_prow;
		logic [PIX_W-1:0]      v_crow;
		logic [M_W-1:0]        v_pm;
		logic [M_W-1:0]        v_cm;
		logic                  h_found;
		logic                  h_first;
		logic [PIX_W-1:0]      h_prow;
		logic [PIX_W-1:0]      h_crow;
		logic [PIX_W-1:0]      h_pspan;
		logic [PIX_W-1:0]      h_cspan;
		logic [M_W-1:0]        h_pm;
		logic [M_W-1:0]        h_cm;
	} srch_t;

	// Finished query result
	typedef struct packed {
		logic signed [M_W-1:0] lateral;
		logic [M_W-1:0]        forward;
		status_t               status;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE, S_FWD, S_FM0, S_FM1, S_FM2, S_FDIV, S_FWAIT,
		S_HOR, S_TM0, S_TM1, S_TDIV, S_TWAIT, S_TNEXT,
		S_LM0, S_LM1, S_LM2, S_LDIV, S_LWAIT, S_OUT
	} calc_state_t;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [M_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
		logic fits;
		fits = (&x[PROD_W-1:M_W-1]) || !(|x[PROD_W-1:M_W-1]);
		if (fits)
			return x[M_W-1:0];
		else if (x[PROD_W-1])
			return 32'sh8000_0000;
		else
			return 32'sh7FFF_FFFF;
	endfunction

endpackage

### design/pixel_to_ground_lut_interp_top.sv
// Pixel-to-ground lookup block, top level: config registers, item handshake,
// cell chain and result register. Depends on p2g_pkg, p2g_cell, p2g_calc.
//
// Write items (opcodes 0 and 1) load one vertical or horizontal calibration
// entry; they give no result. A query (opcode 2) walks a search packet down a
// chain of TABLE_DEPTH cells, one cell per cycle, then interpolates on a
// single shared multiplier and a radix-2 divider that yields one quotient
// bit per cycle. A query runs up to four divisions (forward, two lateral
// terms, lateral blend). The item side stalls while a query is in progress;
// a finished result waits in the output register while the next item is
// taken. Table entries must be written before a query reads them.
module pixel_to_ground_lut_interp_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// item channel
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [1:0]                 opcode,
	input  logic [3:0]                 entry_index,
	input  logic [11:0]                row_pixel,
	input  logic [11:0]                span_pixels,
	input  logic [31:0]                entry_meters,
	input  logic [11:0]                box_left,
	input  logic [11:0]                box_top,
	input  logic [11:0]                box_height,
	// result channel
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [31:0]         lateral_meters,
	output logic [31:0]                forward_meters,
	output logic [1:0]                 status,
	// configuration channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [11:0]                cfg_data
);

	logic [p2g_pkg::PIX_W-1:0]          frame_height_q;
	logic [p2g_pkg::PIX_W-1:0]          sensor_width_q;
	logic [p2g_pkg::CNT_W-1:0]          vert_count_q;
	logic [p2g_pkg::CNT_W-1:0]          horz_count_q;
	logic                               busy_q;
	logic                               item_fire;
	logic                               query_fire;
	logic signed [p2g_pkg::DX_W-1:0]    dx_q;
	logic signed [p2g_pkg::DX_W-1:0]    dx_d;
	logic [p2g_pkg::PIX_W:0]            box_bottom;
	logic signed [p2g_pkg::R_W-1:0]     r_d;
	p2g_pkg::tbl_wr_t                   wr;
	p2g_pkg::srch_t                     link [p2g_pkg::TABLE_DEPTH:0];
	logic                               res_valid;
	logic                               res_take;
	p2g_pkg::res_t                      res;
	logic                               result_valid_q;
	p2g_pkg::res_t                      result_q;

	assign cfg_ready  = 1'b1;
	assign item_stall = busy_q;
	assign item_fire  = item_valid && !item_stall;
	assign query_fire = item_fire && (opcode == p2g_pkg::OP_QUERY);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_height_q <= p2g_pkg::FRAME_HEIGHT_RST;
			sensor_width_q <= p2g_pkg::SENSOR_WIDTH_RST;
			vert_count_q   <= '0;
			horz_count_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				p2g_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				p2g_pkg::CFG_SENSOR_WIDTH: sensor_width_q <= cfg_data;
				p2g_pkg::CFG_VERT_COUNT:   vert_count_q   <= cfg_data[p2g_pkg::CNT_W-1:0];
				p2g_pkg::CFG_HORZ_COUNT:   horz_count_q   <= cfg_data[p2g_pkg::CNT_W-1:0];
			endcase
		end
	end

	// table write decode
	always_comb begin
		wr         = '0;
		wr.index   = entry_index;
		wr.row     = row_pixel;
		wr.span    = span_pixels;
		wr.meters  = entry_meters;
		if (item_fire) begin
			priority case (opcode)
				p2g_pkg::OP_WR_VERT: wr.vert_we = 1'b1;
				p2g_pkg::OP_WR_HORZ: wr.horz_we = 1'b1;
				default: ;
			endcase
		end
	end

	// query row from frame bottom and column offset from center
	assign box_bottom = {1'b0, box_top} + {1'b0, box_height};
	assign r_d  = $signed({2'b00, frame_height_q}) - $signed({1'b0, box_bottom});
	assign dx_d = $signed({1'b0, box_left}) - $signed({2'b00, sensor_width_q[p2g_pkg::PIX_W-1:1]});

	always_comb begin
		link[0]     = '0;
		link[0].vld = query_fire;
		link[0].r   = r_d;
	end

	always_ff @(posedge clk) begin
		if (query_fire)
			dx_q <= dx_d;
	end

	// busy from query accept until its result is handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (query_fire) begin
			busy_q <= 1'b1;
		end else if (res_take) begin
			busy_q <= 1'b0;
		end
	end

	// cell chain
	for (genvar k = 0; k < p2g_pkg::TABLE_DEPTH; k++) begin : g_cell
		p2g_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (p2g_pkg::IDX_W'(k)),
			.wr         (wr),
			.vert_count (vert_count_q),
			.horz_count (horz_count_q),
			.pkt_in     (link[k]),
			.pkt_out    (link[k+1])
		);
	end

	p2g_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_in    (link[p2g_pkg::TABLE_DEPTH]),
		.dx        (dx_q),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// output register
	assign res_take = res_valid && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take)
			result_q <= res;
	end

	assign result_valid   = result_valid_q;
	assign lateral_meters = result_q.lateral;
	assign forward_meters = result_q.forward;
	assign status         = result_q.status;

endmodule

### design/p2g_cell.sv
// One table cell: holds one vertical and one horizontal entry and advances
// the search packet by one position per cycle. Depends on p2g_pkg.
module p2g_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [p2g_pkg::IDX_W-1:0]   cell_idx,
	input  p2g_pkg::tbl_wr_t            wr,
	input  logic [p2g_pkg::CNT_W-1:0]   vert_count,
	input  logic [p2g_pkg::CNT_W-1:0]   horz_count,
	input  p2g_pkg::srch_t              pkt_in,
	output p2g_pkg::srch_t              pkt_out
);

	logic [p2g_pkg::PIX_W-1:0] vrow_q;
	logic [p2g_pkg::M_W-1:0]   vm_q;
	logic [p2g_pkg::PIX_W-1:0] hrow_q;
	logic [p2g_pkg::PIX_W-1:0] hspan_q;
	logic [p2g_pkg::M_W-1:0]   hm_q;
	logic                      hit;
	logic                      v_live;
	logic                      h_live;
	logic                      is_first;
	p2g_pkg::srch_t            nxt;
	p2g_pkg::srch_t            pkt_q;

	assign hit = (p2g_pkg::CMP_W'(wr.index) == p2g_pkg::CMP_W'(cell_idx));
	assign v_live = p2g_pkg::CMP_W'(cell_idx) < p2g_pkg::CMP_W'(vert_count);
	assign h_live = p2g_pkg::CMP_W'(cell_idx) < p2g_pkg::CMP_W'(horz_count);
	assign is_first = (cell_idx == '0);

	// entry storage
	always_ff @(posedge clk) begin
		if (wr.vert_we && hit) begin
			vrow_q <= wr.row;
			vm_q   <= wr.meters;
		end
		if (wr.horz_we && hit) begin
			hrow_q  <= wr.row;
			hspan_q <= wr.span;
			hm_q    <= wr.meters;
		end
	end

	// first-match search step
	always_comb begin
		nxt = pkt_in;
		if (pkt_in.vld) begin
			if (!pkt_in.v_found) begin
				if (v_live && (pkt_in.r <= $signed({2'b00, vrow_q}))) begin
					nxt.v_found = 1'b1;
					nxt.v_first = is_first;
					nxt.v_crow  = vrow_q;
					nxt.v_cm    = vm_q;
				end else begin
					nxt.v_prow = vrow_q;
					nxt.v_pm   = vm_q;
				end
			end
			if (!pkt_in.h_found) begin
				if (h_live && (pkt_in.r <= $signed({2'b00, hrow_q}))) begin
					nxt.h_found = 1'b1;
					nxt.h_first = is_first;
					nxt.h_crow  = hrow_q;
					nxt.h_cspan = hspan_q;
					nxt.h_cm    = hm_q;
				end else begin
					nxt.h_prow  = hrow_q;
					nxt.h_pspan = hspan_q;
					nxt.h_pm    = hm_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else begin
			pkt_q <= nxt;
		end
	end

	assign pkt_out = pkt_q;

endmodule

### design/p2g_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on p2g_pkg for widths.
module p2g_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [p2g_pkg::DIV_W-1:0]   dividend,
	input  logic [p2g_pkg::DVS_W-1:0]   divisor,
	output logic                        done,
	output logic [p2g_pkg::DIV_W-1:0]   quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [p2g_pkg::DCNT_W-1:0]  cnt_q;
	logic [p2g_pkg::DVS_W-1:0]   rem_q;
	logic [p2g_pkg::DVS_W-1:0]   dvs_q;
	logic [p2g_pkg::DIV_W-1:0]   quo_q;
	logic [p2g_pkg::DVS_W:0]     trial;
	logic                        take;

	assign trial = {rem_q, quo_q[p2g_pkg::DIV_W-1]};
	assign take  = (trial >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == p2g_pkg::DCNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= p2g_pkg::DCNT_W'(p2g_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - p2g_pkg::DCNT_W'(1);
				if (cnt_q == p2g_pkg::DCNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (take)
				rem_q <= p2g_pkg::DVS_W'(trial - {1'b0, dvs_q});
			else
				rem_q <= trial[p2g_pkg::DVS_W-1:0];
			quo_q <= {quo_q[p2g_pkg::DIV_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/p2g_calc.sv
// Interpolation sequencer: turns the matched table entries into forward and
// lateral distances with one shared multiplier and divider. Depends on
// p2g_pkg and p2g_div.
module p2g_calc (
	input  logic                              clk,
	input  logic                              arst_n,
	input  p2g_pkg::srch_t                    pkt_in,
	input  logic signed [p2g_pkg::DX_W-1:0]   dx,
	output logic                              res_valid,
	input  logic                              res_take,
	output p2g_pkg::res_t                     res
);

	p2g_pkg::calc_state_t                 state_q;
	p2g_pkg::calc_state_t                 state_d;
	p2g_pkg::srch_t                       pkt_q;
	p2g_pkg::status_t                     st_q;
	logic [p2g_pkg::M_W-1:0]              fwd_q;
	logic signed [p2g_pkg::M_W-1:0]       lat_q;
	logic signed [p2g_pkg::PROD_W-1:0]    prod_q;
	logic signed [p2g_pkg::PROD_W-1:0]    acc_q;
	logic signed [p2g_pkg::PROD_W-1:0]    acc_abs;
	logic signed [p2g_pkg::TERM_W-1:0]    v0_q;
	logic signed [p2g_pkg::TERM_W-1:0]    v1_q;
	logic signed [p2g_pkg::TERM_W-1:0]    tval;
	logic signed [p2g_pkg::PROD_W-1:0]    lq;
	logic                                 term_prev_q;
	logic                                 neg_q;
	logic signed [p2g_pkg::MUL_A_W-1:0]   mul_a;
	logic signed [p2g_pkg::MUL_B_W-1:0]   mul_b;
	logic                                 div_start;
	logic [p2g_pkg::DIV_W-1:0]            div_dividend;
	logic [p2g_pkg::DVS_W-1:0]            div_divisor;
	logic                                 div_done;
	logic [p2g_pkg::DIV_W-1:0]            div_quo;
	logic signed [p2g_pkg::R_W-1:0]       vw0_f, vw1_f, hw0_f, hw1_f;
	logic [p2g_pkg::PIX_W-1:0]            vw0, vw1, vgap, hw0, hw1, hgap;
	logic                                 dx_neg;
	logic [p2g_pkg::DX_W-1:0]             dx_abs;
	logic [p2g_pkg::PIX_W-1:0]            dx_mag;
	logic                                 span_zero;

	// interpolation weights and gaps
	assign vw0_f = $signed({2'b00, pkt_q.v_crow}) - pkt_q.r;
	assign vw1_f = pkt_q.r - $signed({2'b00, pkt_q.v_prow});
	assign hw0_f = $signed({2'b00, pkt_q.h_crow}) - pkt_q.r;
	assign hw1_f = pkt_q.r - $signed({2'b00, pkt_q.h_prow});
	assign vw0   = vw0_f[p2g_pkg::PIX_W-1:0];
	assign vw1   = vw1_f[p2g_pkg::PIX_W-1:0];
	assign hw0   = hw0_f[p2g_pkg::PIX_W-1:0];
	assign hw1   = hw1_f[p2g_pkg::PIX_W-1:0];
	assign vgap  = pkt_q.v_crow - pkt_q.v_prow;
	assign hgap  = pkt_q.h_crow - pkt_q.h_prow;

	assign dx_neg = dx[p2g_pkg::DX_W-1];
	assign dx_abs = dx_neg ? -dx : dx;
	assign dx_mag = dx_abs[p2g_pkg::PIX_W-1:0];

	assign span_zero = (pkt_q.h_cspan == '0) || (!pkt_q.h_first && (pkt_q.h_pspan == '0));

	assign acc_abs = acc_q[p2g_pkg::PROD_W-1] ? -acc_q : acc_q;
	assign tval    = dx_neg ? -$signed({1'b0, div_quo[p2g_pkg::TERM_W-2:0]})
	                        :  $signed({1'b0, div_quo[p2g_pkg::TERM_W-2:0]});
	assign lq      = $signed({2'b00, div_quo});

	p2g_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= p2g_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, multiplier and divider operands
	always_comb begin
		state_d      = state_q;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		res_valid    = 1'b0;
		unique case (state_q)
			p2g_pkg::S_IDLE: begin
				if (pkt_in.vld)
					state_d = p2g_pkg::S_FWD;
			end
			p2g_pkg::S_FWD: begin
				if (!pkt_q.v_found || pkt_q.v_first || (vgap == '0))
					state_d = p2g_pkg::S_HOR;
				else
					state_d = p2g_pkg::S_FM0;
			end
			p2g_pkg::S_FM0: begin
				mul_a   = $signed({14'd0, pkt_q.v_pm});
				mul_b   = $signed({2'b00, vw0});
				state_d = p2g_pkg::S_FM1;
			end
			p2g_pkg::S_FM1: begin
				mul_a   = $signed({14'd0, pkt_q.v_cm});
				mul_b   = $signed({2'b00, vw1});
				state_d = p2g_pkg::S_FM2;
			end
			p2g_pkg::S_FM2: state_d = p2g_pkg::S_FDIV;
			p2g_pkg::S_FDIV: begin
				div_start    = 1'b1;
				div_dividend = acc_q[p2g_pkg::DIV_W-1:0];
				div_divisor  = {1'b0, vgap};
				state_d      = p2g_pkg::S_FWAIT;
			end
			p2g_pkg::S_FWAIT: begin
				if (div_done)
					state_d = p2g_pkg::S_HOR;
			end
			p2g_pkg::S_HOR: begin
				if (!pkt_q.h_found || span_zero)
					state_d = p2g_pkg::S_OUT;
				else
					state_d = p2g_pkg::S_TM0;
			end
			p2g_pkg::S_TM0: begin
				mul_a   = $signed({14'd0, term_prev_q ? pkt_q.h_pm : pkt_q.h_cm});
				mul_b   = $signed({2'b00, dx_mag});
				state_d = p2g_pkg::S_TM1;
			end
			p2g_pkg::S_TM1: state_d = p2g_pkg::S_TDIV;
			p2g_pkg::S_TDIV: begin
				div_start    = 1'b1;
				div_dividend = acc_q[p2g_pkg::DIV_W-1:0];
				div_divisor  = {term_prev_q ? pkt_q.h_pspan : pkt_q.h_cspan, 1'b0};
				state_d      = p2g_pkg::S_TWAIT;
			end
			p2g_pkg::S_TWAIT: begin
				if (div_done)
					state_d = p2g_pkg::S_TNEXT;
			end
			p2g_pkg::S_TNEXT: begin
				if (pkt_q.h_first || (hgap == '0))
					state_d = p2g_pkg::S_OUT;
				else if (!term_prev_q)
					state_d = p2g_pkg::S_TM0;
				else
					state_d = p2g_pkg::S_LM0;
			end
			p2g_pkg::S_LM0: begin
				mul_a   = {v0_q[p2g_pkg::TERM_W-1], v0_q};
				mul_b   = $signed({2'b00, hw0});
				state_d = p2g_pkg::S_LM1;
			end
			p2g_pkg::S_LM1: begin
				mul_a   = {v1_q[p2g_pkg::TERM_W-1], v1_q};
				mul_b   = $signed({2'b00, hw1});
				state_d = p2g_pkg::S_LM2;
			end
			p2g_pkg::S_LM2: state_d = p2g_pkg::S_LDIV;
			p2g_pkg::S_LDIV: begin
				div_start    = 1'b1;
				div_dividend = acc_abs[p2g_pkg::DIV_W-1:0];
				div_divisor  = {1'b0, hgap};
				state_d      = p2g_pkg::S_LWAIT;
			end
			p2g_pkg::S_LWAIT: begin
				if (div_done)
					state_d = p2g_pkg::S_OUT;
			end
			p2g_pkg::S_OUT: begin
				res_valid = 1'b1;
				if (res_take)
					state_d = p2g_pkg::S_IDLE;
			end
			default: state_d = p2g_pkg::S_IDLE;
		endcase
	end

	// product register: one multiply per cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			p2g_pkg::S_IDLE: begin
				if (pkt_in.vld) begin
					pkt_q       <= pkt_in;
					st_q        <= p2g_pkg::ST_OK;
					fwd_q       <= '0;
					lat_q       <= '0;
					term_prev_q <= 1'b0;
				end
			end
			p2g_pkg::S_FWD: begin
				if (!pkt_q.v_found) begin
					st_q <= p2g_pkg::ST_NO_VERT;
				end else if (pkt_q.v_first) begin
					fwd_q <= pkt_q.v_cm;
				end else if (vgap == '0) begin
					fwd_q <= pkt_q.v_cm;
					st_q  <= p2g_pkg::ST_ZERO_GAP;
				end
			end
			p2g_pkg::S_FM1, p2g_pkg::S_TM1, p2g_pkg::S_LM1: acc_q <= prod_q;
			p2g_pkg::S_FM2, p2g_pkg::S_LM2: acc_q <= acc_q + prod_q;
			p2g_pkg::S_FWAIT: begin
				if (div_done)
					fwd_q <= div_quo[p2g_pkg::M_W-1:0];
			end
			p2g_pkg::S_HOR: begin
				if (!pkt_q.h_found) begin
					if (st_q != p2g_pkg::ST_NO_VERT)
						st_q <= p2g_pkg::ST_NO_HORZ;
				end else if (span_zero) begin
					if (st_q == p2g_pkg::ST_OK)
						st_q <= p2g_pkg::ST_ZERO_GAP;
				end
			end
			p2g_pkg::S_TWAIT: begin
				if (div_done) begin
					if (term_prev_q)
						v0_q <= tval;
					else
						v1_q <= tval;
				end
			end
			p2g_pkg::S_TNEXT: begin
				if (pkt_q.h_first) begin
					lat_q <= p2g_pkg::sat32(p2g_pkg::PROD_W'(v1_q));
				end else if (hgap == '0) begin
					lat_q <= p2g_pkg::sat32(p2g_pkg::PROD_W'(v1_q));
					if (st_q == p2g_pkg::ST_OK)
						st_q <= p2g_pkg::ST_ZERO_GAP;
				end else if (!term_prev_q) begin
					term_prev_q <= 1'b1;
				end
			end
			p2g_pkg::S_LDIV: neg_q <= acc_q[p2g_pkg::PROD_W-1];
			p2g_pkg::S_LWAIT: begin
				if (div_done)
					lat_q <= p2g_pkg::sat32(neg_q ? -lq : lq);
			end
			default: ;
		endcase
	end

	assign res.lateral = lat_q;
	assign res.forward = fwd_q;
	assign res.status  = st_q;

endmodule
